[hdl/owk_pkg.sv]
// Shared constants and types for the omni-wheel kinematics block.
`timescale 1ns / 1ps

package owk_pkg;

  localparam int NUM_WHEELS = 4;
  // Components of a twist: vx, vy, omega.
  localparam int NUM_TWIST = 3;

  localparam int DEFAULT_DATA_WIDTH = 24;
  localparam int DEFAULT_COEF_WIDTH = 16;

  localparam int CFG_WIDTH = 64;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int SLOT_WIDTH = 16;
  localparam int SHIFT_WIDTH = 5;

  typedef logic [CFG_WIDTH-1:0] cfg_word_t;
  typedef logic [SHIFT_WIDTH-1:0] shift_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam shift_t SHIFT_RESET = shift_t'(12);

  localparam cfg_index_t REG_FWD_COL_VX    = cfg_index_t'(0);
  localparam cfg_index_t REG_FWD_COL_VY    = cfg_index_t'(1);
  localparam cfg_index_t REG_FWD_COL_OMEGA = cfg_index_t'(2);
  localparam cfg_index_t REG_INV_ROW_VX    = cfg_index_t'(3);
  localparam cfg_index_t REG_INV_ROW_VY    = cfg_index_t'(4);
  localparam cfg_index_t REG_INV_ROW_OMEGA = cfg_index_t'(5);
  localparam cfg_index_t REG_FWD_SHIFT     = cfg_index_t'(6);
  localparam cfg_index_t REG_INV_SHIFT     = cfg_index_t'(7);

  localparam logic ACTION_FORWARD = 1'b0;
  localparam logic ACTION_INVERSE = 1'b1;

endpackage

[hdl/omni_wheel_kinematics.sv]
// Four-wheel omni-drive kinematics: twist to wheel speeds and back, in fixed point.
`timescale 1ns / 1ps

// Takes one word per clock cycle while the output side is not stalled and returns one
// result word per input word. An accepted word is held in the input register and
// then loaded into the result register, from which it is offered on the output.
// Between the two registers sit sixteen parallel coefficient multipliers, a four-term
// adder per output, the arithmetic right shift and the saturation clip. tuser on the
// input selects forward (0) or inverse (1); tuser on the output is the saturation flag.
// Coefficients and shifts are written through the cfg port; the user must write them
// only while no word is in flight, as the block itself does not enforce it.
module omni_wheel_kinematics
  import owk_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  parameter int COEF_WIDTH = DEFAULT_COEF_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // in0, in1, in2, in3 from the lowest bit up, zero padded to whole bytes
  input  logic [((NUM_WHEELS*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // action
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out0, out1, out2, out3 from the lowest bit up, zero padded to whole bytes
  output logic [((NUM_WHEELS*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // saturated
  output logic m_tuser,
  input  logic cfg_wr_en,
  input  cfg_index_t cfg_index,
  input  cfg_word_t cfg_data
);

  localparam int TDATA_WIDTH = ((NUM_WHEELS*DATA_WIDTH+7)/8)*8;
  localparam int PACK_WIDTH = NUM_WHEELS*DATA_WIDTH;
  localparam int PROD_WIDTH = DATA_WIDTH + COEF_WIDTH;
  // Four products summed need two extra bits.
  localparam int SUM_WIDTH = PROD_WIDTH + 2;

  cfg_word_t fwd_col [NUM_TWIST];
  cfg_word_t inv_row [NUM_TWIST];
  shift_t fwd_shift;
  shift_t inv_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TWIST; i++) begin
        fwd_col[i] <= '0;
        inv_row[i] <= '0;
      end
      fwd_shift <= SHIFT_RESET;
      inv_shift <= SHIFT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FWD_COL_VX:    fwd_col[0] <= cfg_data;
        REG_FWD_COL_VY:    fwd_col[1] <= cfg_data;
        REG_FWD_COL_OMEGA: fwd_col[2] <= cfg_data;
        REG_INV_ROW_VX:    inv_row[0] <= cfg_data;
        REG_INV_ROW_VY:    inv_row[1] <= cfg_data;
        REG_INV_ROW_OMEGA: inv_row[2] <= cfg_data;
        REG_FWD_SHIFT:     fwd_shift <= cfg_data[SHIFT_WIDTH-1:0];
        REG_INV_SHIFT:     inv_shift <= cfg_data[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register, loaded while s_tready, and result register, loaded on advance.
  logic in_valid;
  logic in_action;
  logic signed [DATA_WIDTH-1:0] in_x [NUM_WHEELS];
  logic out_valid;
  logic [PACK_WIDTH-1:0] out_data;
  logic out_sat;
  logic advance;

  logic [PACK_WIDTH-1:0] res_data;
  logic [NUM_WHEELS-1:0] res_sat;
  shift_t shift_sel;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign shift_sel = (in_action == ACTION_INVERSE) ? inv_shift : fwd_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        in_x[w] <= s_tdata[DATA_WIDTH*w +: DATA_WIDTH];
      end
    end
  end

  genvar k, j;
  generate
    for (k = 0; k < NUM_WHEELS; k++) begin : g_out
      logic signed [PROD_WIDTH-1:0] prod [NUM_WHEELS];
      logic signed [SUM_WIDTH-1:0] sum;
      logic signed [SUM_WIDTH-1:0] shifted;
      logic [SUM_WIDTH-DATA_WIDTH:0] upper;
      logic in_range;

      for (j = 0; j < NUM_WHEELS; j++) begin : g_term
        logic signed [COEF_WIDTH-1:0] cf;
        // Forward uses column j slot k; inverse uses row k slot j. Terms that
        // fall outside the 3x4 or 4x3 matrix carry a zero coefficient.
        if (k < NUM_TWIST && j < NUM_TWIST) begin : g_both
          assign cf = (in_action == ACTION_INVERSE)
                      ? inv_row[k][SLOT_WIDTH*j +: COEF_WIDTH]
                      : fwd_col[j][SLOT_WIDTH*k +: COEF_WIDTH];
        end else if (k < NUM_TWIST) begin : g_inv
          assign cf = (in_action == ACTION_INVERSE)
                      ? inv_row[k][SLOT_WIDTH*j +: COEF_WIDTH] : '0;
        end else if (j < NUM_TWIST) begin : g_fwd
          assign cf = (in_action == ACTION_INVERSE)
                      ? '0 : fwd_col[j][SLOT_WIDTH*k +: COEF_WIDTH];
        end else begin : g_none
          assign cf = '0;
        end
        assign prod[j] = PROD_WIDTH'(cf) * PROD_WIDTH'(in_x[j]);
      end

      assign sum = SUM_WIDTH'(prod[0]) + SUM_WIDTH'(prod[1])
                 + SUM_WIDTH'(prod[2]) + SUM_WIDTH'(prod[3]);
      assign shifted = sum >>> shift_sel;
      // The value fits when every bit from the output sign bit up agrees.
      assign upper = shifted[SUM_WIDTH-1:DATA_WIDTH-1];
      assign in_range = (&upper) || !(|upper);
      assign res_sat[k] = !in_range;
      always_comb begin
        if (in_range) begin
          res_data[DATA_WIDTH*k +: DATA_WIDTH] = shifted[DATA_WIDTH-1:0];
        end else if (shifted[SUM_WIDTH-1]) begin
          res_data[DATA_WIDTH*k +: DATA_WIDTH] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
          res_data[DATA_WIDTH*k +: DATA_WIDTH] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= res_data;
      out_sat  <= |res_sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_WIDTH'(out_data);
  assign m_tuser  = out_sat;

endmodule

[hdl/owk_checker.sv]
// Port-level checks for the omni-wheel kinematics block, bound to its top level.
`timescale 1ns / 1ps

module owk_checker
  import owk_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  parameter int COEF_WIDTH = DEFAULT_COEF_WIDTH
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((NUM_WHEELS*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic m_tuser
);

  localparam int SUM_GUARD = DATA_WIDTH + COEF_WIDTH;

  // A reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word pending after reset");

  // A stalled result word is held unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // An accepted word reaches the output unless the output side stalls it.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 (m_tready && SUM_GUARD > 0) |=> m_tvalid)
    else $error("accepted word did not reach the output");

  // A new result word only appears after an accepted input word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) && !$past(rst) && !$past(rst, 2)
    |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without an input word");

endmodule

bind omni_wheel_kinematics owk_checker #(
  .DATA_WIDTH(DATA_WIDTH),
  .COEF_WIDTH(COEF_WIDTH)
) u_owk_checker (.*);

[tb/owk_kinematics_checker.sv]
// Checker for the omni-wheel kinematics block: predicts each result word and compares it.
`timescale 1ns / 1ps

module owk_kinematics_checker
  import owk_pkg::*;
#(
  parameter int DW = DEFAULT_DATA_WIDTH,
  parameter int CW = DEFAULT_COEF_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // in0, in1, in2, in3 from the lowest bit up
  input  logic [((NUM_WHEELS*DW+7)/8)*8-1:0] s_tdata,
  // action
  input  logic s_tuser,
  input  logic m_tvalid,
  input  logic m_tready,
  // out0, out1, out2, out3 from the lowest bit up
  input  logic [((NUM_WHEELS*DW+7)/8)*8-1:0] m_tdata,
  // saturated
  input  logic m_tuser,
  input  logic cfg_wr_en,
  input  cfg_index_t cfg_index,
  input  cfg_word_t cfg_data,
  output int mismatches,
  output int pending
);

  localparam int TW = ((NUM_WHEELS*DW+7)/8)*8;

  cfg_word_t fwd_col[NUM_TWIST];
  cfg_word_t inv_row[NUM_TWIST];
  shift_t fwd_sh;
  shift_t inv_sh;

  // Predicted output words, saturation flag in the top bit.
  logic [TW:0] due_words[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic longint coef(cfg_word_t w, int slot);
    return longint'($signed(w[slot*SLOT_WIDTH +: CW]));
  endfunction

  // Floor shift, then clip to the signed data range.
  function automatic logic [DW-1:0] clip(longint acc, shift_t sh, inout logic sat);
    longint v;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DW-1)) - 1;
    lo = -hi - 1;
    v = acc >>> sh;
    if (v > hi) begin
      v = hi;
      sat = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      sat = 1'b1;
    end
    return v[DW-1:0];
  endfunction

  function automatic logic [TW:0] kinematics_predict(logic act, logic [TW-1:0] d);
    longint x[NUM_WHEELS];
    longint acc;
    logic [TW-1:0] r;
    logic sat;
    r = '0;
    sat = 1'b0;
    for (int i = 0; i < NUM_WHEELS; i++) x[i] = longint'($signed(d[i*DW +: DW]));
    if (act == ACTION_FORWARD) begin
      // The fourth input plays no part in the forward direction.
      for (int w = 0; w < NUM_WHEELS; w++) begin
        acc = 0;
        for (int t = 0; t < NUM_TWIST; t++) acc += coef(fwd_col[t], w) * x[t];
        r[w*DW +: DW] = clip(acc, fwd_sh, sat);
      end
    end else begin
      // The fourth output stays zero and never sets the flag.
      for (int t = 0; t < NUM_TWIST; t++) begin
        acc = 0;
        for (int w = 0; w < NUM_WHEELS; w++) acc += coef(inv_row[t], w) * x[w];
        r[t*DW +: DW] = clip(acc, inv_sh, sat);
      end
    end
    return {sat, r};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic [TW:0] want;
    if (rst) begin
      foreach (fwd_col[t]) fwd_col[t] = '0;
      foreach (inv_row[t]) inv_row[t] = '0;
      fwd_sh = SHIFT_RESET;
      inv_sh = SHIFT_RESET;
      due_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word", longint'(m_tdata[DW-1:0]), 0);
        end else begin
          want = due_words.pop_front();
          for (int f = 0; f < NUM_WHEELS; f++) begin
            if (m_tdata[f*DW +: DW] !== want[f*DW +: DW])
              report_mismatch($sformatf("out%0d", f),
                              longint'($signed(m_tdata[f*DW +: DW])),
                              longint'($signed(want[f*DW +: DW])));
          end
          if (m_tuser !== want[TW])
            report_mismatch("saturated", longint'(m_tuser), longint'(want[TW]));
        end
      end
      if (s_tvalid && s_tready) due_words.push_back(kinematics_predict(s_tuser, s_tdata));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FWD_COL_VX:    fwd_col[0] = cfg_data;
          REG_FWD_COL_VY:    fwd_col[1] = cfg_data;
          REG_FWD_COL_OMEGA: fwd_col[2] = cfg_data;
          REG_INV_ROW_VX:    inv_row[0] = cfg_data;
          REG_INV_ROW_VY:    inv_row[1] = cfg_data;
          REG_INV_ROW_OMEGA: inv_row[2] = cfg_data;
          REG_FWD_SHIFT:     fwd_sh = cfg_data[SHIFT_WIDTH-1:0];
          REG_INV_SHIFT:     inv_sh = cfg_data[SHIFT_WIDTH-1:0];
          default: ;
        endcase
      end
    end
    pending = due_words.size();
  end

endmodule

[tb/tb_omni_wheel_kinematics.sv]
// Testbench top for the omni-wheel kinematics block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_omni_wheel_kinematics;
  import owk_pkg::*;

  localparam int DW = DEFAULT_DATA_WIDTH;
  localparam int TW = ((NUM_WHEELS*DW+7)/8)*8;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ZERO = '0;
  localparam logic [DW-1:0] ONE = DW'(1);
  localparam logic [DW-1:0] MINUS_ONE = '1;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TW-1:0] s_tdata = '0;
  logic s_tuser = ACTION_FORWARD;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TW-1:0] m_tdata;
  logic m_tuser;
  logic cfg_wr_en = 1'b0;
  cfg_index_t cfg_index = REG_FWD_COL_VX;
  cfg_word_t cfg_data = '0;

  int mismatches;
  int pending;

  // Set by the stimulus: no idling on either side, or a long receiver hold-off.
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  cfg_word_t setting[8];

  omni_wheel_kinematics i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  owk_kinematics_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic act, input logic [DW-1:0] a, input logic [DW-1:0] b,
                           input logic [DW-1:0] c, input logic [DW-1:0] d);
    while (!steady && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {d, c, b, a};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Registers are only written once every word in flight has come out.
  task automatic apply_setting;
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data <= setting[i];
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [DW-1:0] rand_sample;
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2: return DW'($urandom_range(0, 32)) - DW'(16);
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic cfg_word_t rand_coef_word;
    cfg_word_t w;
    w = {$urandom, $urandom};
    for (int s = 0; s < NUM_WHEELS; s++) begin
      case ($urandom_range(0, 7))
        0: w[s*SLOT_WIDTH +: SLOT_WIDTH] = 16'h8000;
        1: w[s*SLOT_WIDTH +: SLOT_WIDTH] = 16'h7fff;
        2: w[s*SLOT_WIDTH +: SLOT_WIDTH] = 16'h0000;
        3: w[s*SLOT_WIDTH +: SLOT_WIDTH] = 16'($urandom_range(0, 64)) - 16'd32;
        default: ;
      endcase
    end
    return w;
  endfunction

  // Junk in the upper bits of a shift write must be ignored.
  function automatic cfg_word_t rand_shift_word;
    cfg_word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: w[SHIFT_WIDTH-1:0] = '0;
      1: w[SHIFT_WIDTH-1:0] = '1;
      2: w[SHIFT_WIDTH-1:0] = shift_t'($urandom_range(0, 31));
      default: w[SHIFT_WIDTH-1:0] = shift_t'($urandom_range(14, 22));
    endcase
    return w;
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Power-on coefficients are zero, so every result is zero.
    send_word(ACTION_FORWARD, SMAX, SMIN, SMAX, SMIN);
    send_word(ACTION_INVERSE, SMIN, SMAX, ONE, MINUS_ONE);

    // Extreme coefficients with no shift: saturation either way.
    setting[REG_FWD_COL_VX] = {4{16'h8000}};
    setting[REG_FWD_COL_VY] = {4{16'h7fff}};
    setting[REG_FWD_COL_OMEGA] = {16'h7fff, 16'h8000, 16'hffff, 16'h0001};
    setting[REG_INV_ROW_VX] = {4{16'h7fff}};
    setting[REG_INV_ROW_VY] = {4{16'h8000}};
    setting[REG_INV_ROW_OMEGA] = {16'hffff, 16'h0001, 16'h8000, 16'h7fff};
    setting[REG_FWD_SHIFT] = 64'hffff_ffff_ffff_ffe0;
    setting[REG_INV_SHIFT] = 64'h5a5a_5a5a_5a5a_5a40;
    apply_setting();
    send_word(ACTION_FORWARD, SMAX, SMAX, SMAX, SMIN);
    send_word(ACTION_FORWARD, SMIN, SMIN, SMIN, SMAX);
    send_word(ACTION_FORWARD, ZERO, ZERO, ZERO, SMAX);
    send_word(ACTION_FORWARD, ONE, MINUS_ONE, ONE, ZERO);
    send_word(ACTION_INVERSE, SMAX, SMAX, SMAX, SMAX);
    send_word(ACTION_INVERSE, SMIN, SMIN, SMIN, SMIN);
    send_word(ACTION_INVERSE, ONE, DW'(2), -DW'(3), DW'(4));

    // Largest shift: small negative sums must round down to minus one.
    setting[REG_FWD_SHIFT] = 64'h0000_0000_0000_001f;
    setting[REG_INV_SHIFT] = 64'ha5a5_a5a5_a5a5_a5bf;
    apply_setting();
    send_word(ACTION_FORWARD, SMIN, ZERO, ZERO, ZERO);
    send_word(ACTION_FORWARD, SMAX, ZERO, ZERO, ZERO);
    send_word(ACTION_FORWARD, MINUS_ONE, ZERO, ZERO, ZERO);
    send_word(ACTION_FORWARD, ONE, ZERO, ZERO, ZERO);
    send_word(ACTION_INVERSE, ONE, ZERO, ZERO, ZERO);
    send_word(ACTION_INVERSE, MINUS_ONE, ZERO, ZERO, ZERO);

    // Unit gain in Q12: values pass through, sums of extremes clip.
    setting[REG_FWD_COL_VX] = {4{16'h1000}};
    setting[REG_FWD_COL_VY] = {4{16'h1000}};
    setting[REG_FWD_COL_OMEGA] = {4{16'h1000}};
    setting[REG_INV_ROW_VX] = {4{16'h1000}};
    setting[REG_INV_ROW_VY] = {16'h0000, 16'h0000, 16'h1000, 16'hf000};
    setting[REG_INV_ROW_OMEGA] = {16'h1000, 16'h0000, 16'h0000, 16'h0000};
    setting[REG_FWD_SHIFT] = 64'd12;
    setting[REG_INV_SHIFT] = 64'd12;
    apply_setting();
    send_word(ACTION_FORWARD, SMAX, ZERO, ZERO, SMIN);
    send_word(ACTION_FORWARD, ZERO, SMIN, ZERO, ZERO);
    send_word(ACTION_INVERSE, SMAX, ZERO, ZERO, ZERO);
    send_word(ACTION_INVERSE, SMIN, SMIN, ZERO, ZERO);

    for (int phase = 0; phase < 8; phase++) begin
      setting[REG_FWD_COL_VX] = rand_coef_word();
      setting[REG_FWD_COL_VY] = rand_coef_word();
      setting[REG_FWD_COL_OMEGA] = rand_coef_word();
      setting[REG_INV_ROW_VX] = rand_coef_word();
      setting[REG_INV_ROW_VY] = rand_coef_word();
      setting[REG_INV_ROW_OMEGA] = rand_coef_word();
      setting[REG_FWD_SHIFT] = rand_shift_word();
      setting[REG_INV_SHIFT] = rand_shift_word();
      apply_setting();
      steady = (phase == 2);
      for (int n = 0; n < 125; n++) begin
        // Keep offering words while the receiver is held off so the input backs up.
        if (phase == 3 && n == 40) hold_req = 1'b1;
        if (phase == 5 && n == 60) drain();
        send_word($urandom_range(0, 1) ? ACTION_INVERSE : ACTION_FORWARD,
                  rand_sample(), rand_sample(), rand_sample(), rand_sample());
      end
      steady = 1'b0;
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/owk_pkg.sv
hdl/omni_wheel_kinematics.sv
hdl/owk_checker.sv
tb/owk_kinematics_checker.sv
tb/tb_omni_wheel_kinematics.sv
